/* design/osc_pkg.sv */
// Shared types and constants for the Ogg stream carver.
package osc_pkg;

  localparam int POS_W      = 32;
  localparam int LEN_W      = 17;
  localparam int CNT_W      = 5;
  localparam int OUT_DATA_W = 72;

  localparam logic [23:0] CAPTURE_HEAD    = 24'h4f6767;
  localparam logic [7:0]  CAPTURE_TAIL    = 8'h53;
  localparam logic [8:0]  FIXED_HEADER    = 9'd27;
  localparam logic [CNT_W-1:0] TYPE_WAIT  = CNT_W'(5 - 3);
  localparam logic [CNT_W-1:0] SEGCNT_WAIT = CNT_W'(26 - 5);
  localparam int FLAG_BOS_BIT = 1;
  localparam int FLAG_EOS_BIT = 2;

  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_FOUND     = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_SCAN,
    PH_TYPE,
    PH_HEADER,
    PH_LACING
  } phase_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [POS_W-1:0] begin_pos;
    logic [POS_W-1:0] end_pos;
  } result_t;

endpackage

/* design/osc_scan.sv */
// Page scanner: capture-pattern search, header walk and lacing sum, one byte a beat.
module osc_scan (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    beat_acc,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  input  logic [osc_pkg::POS_W-1:0] start_offset,
  output osc_pkg::result_t        res
);
  import osc_pkg::*;

  logic [23:0]      window_r, window_nxt;
  logic [POS_W-1:0] position_r, position_nxt;
  logic [POS_W-1:0] stream_begin_r, stream_begin_nxt;
  logic             begin_valid_r, begin_valid_nxt;
  logic [POS_W-1:0] page_start_r, page_start_nxt;
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] countdown_r, countdown_nxt;
  logic [7:0]       segs_left_r, segs_left_nxt;
  logic [LEN_W-1:0] page_len_r, page_len_nxt;
  logic             finished_r, finished_nxt;
  logic             set_open_r, set_open_nxt;
  logic             done;
  logic [POS_W-1:0] cur_pos;
  logic [CNT_W-1:0] count_dec;
  phase_t           step_phase;
  logic [POS_W-1:0] step_begin;
  logic [POS_W-1:0] step_end;

  assign cur_pos   = set_open_r ? position_r : start_offset;
  assign count_dec = countdown_r - CNT_W'(1);

  // next state
  always_comb begin
    window_nxt       = {window_r[15:0], data_byte};
    position_nxt     = cur_pos + POS_W'(1);
    stream_begin_nxt = stream_begin_r;
    begin_valid_nxt  = begin_valid_r;
    page_start_nxt   = page_start_r;
    phase_nxt        = phase_r;
    countdown_nxt    = countdown_r;
    segs_left_nxt    = segs_left_r;
    page_len_nxt     = page_len_r;
    finished_nxt     = finished_r;
    set_open_nxt     = 1'b1;
    done             = 1'b0;
    if (!finished_r) begin
      case (phase_r)
        PH_SCAN: begin
          if (window_r == CAPTURE_HEAD && data_byte == CAPTURE_TAIL) begin
            page_start_nxt = cur_pos - POS_W'(3);
            countdown_nxt  = TYPE_WAIT;
            phase_nxt      = PH_TYPE;
          end
        end
        PH_TYPE: begin
          countdown_nxt = count_dec;
          if (count_dec == '0) begin
            phase_nxt = PH_SCAN;
            // BOS before EOS so one page may open and close the stream
            if (data_byte[FLAG_BOS_BIT]) begin
              stream_begin_nxt = page_start_r;
              begin_valid_nxt  = 1'b1;
            end
            if (data_byte[FLAG_EOS_BIT] && (begin_valid_r || data_byte[FLAG_BOS_BIT])) begin
              phase_nxt     = PH_HEADER;
              countdown_nxt = SEGCNT_WAIT;
            end
          end
        end
        PH_HEADER: begin
          countdown_nxt = count_dec;
          if (count_dec == '0) begin
            segs_left_nxt = data_byte;
            page_len_nxt  = LEN_W'(FIXED_HEADER) + LEN_W'(data_byte);
            if (data_byte == 8'd0) done = 1'b1;
            else                   phase_nxt = PH_LACING;
          end
        end
        PH_LACING: begin
          page_len_nxt  = page_len_r + LEN_W'(data_byte);
          segs_left_nxt = segs_left_r - 8'd1;
          if (segs_left_r == 8'd1) done = 1'b1;
        end
        default: phase_nxt = PH_SCAN;
      endcase
      if (done) begin
        finished_nxt = 1'b1;
        phase_nxt    = PH_SCAN;
      end
    end
    // hold the post-byte view for the result before the set is cleared
    step_phase = phase_nxt;
    step_begin = stream_begin_nxt;
    step_end   = page_start_nxt + POS_W'(page_len_nxt);
    // close the data set: clear everything for the next one
    if (last_byte) begin
      window_nxt       = '0;
      stream_begin_nxt = '0;
      begin_valid_nxt  = 1'b0;
      page_start_nxt   = '0;
      phase_nxt        = PH_SCAN;
      countdown_nxt    = '0;
      segs_left_nxt    = '0;
      page_len_nxt     = '0;
      finished_nxt     = 1'b0;
      set_open_nxt     = 1'b0;
    end
  end

  // outputs
  always_comb begin
    res           = '0;
    res.status    = ST_NOT_FOUND;
    if (beat_acc) begin
      if (done) begin
        res.valid     = 1'b1;
        res.status    = ST_FOUND;
        res.begin_pos = step_begin;
        res.end_pos   = step_end;
      end else if (last_byte && !finished_r) begin
        res.valid = 1'b1;
        if (step_phase == PH_HEADER || step_phase == PH_LACING) begin
          res.status    = ST_TRUNCATED;
          res.begin_pos = step_begin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r       <= '0;
      position_r     <= '0;
      stream_begin_r <= '0;
      begin_valid_r  <= 1'b0;
      page_start_r   <= '0;
      phase_r        <= PH_SCAN;
      countdown_r    <= '0;
      segs_left_r    <= '0;
      page_len_r     <= '0;
      finished_r     <= 1'b0;
      set_open_r     <= 1'b0;
    end else if (beat_acc) begin
      window_r       <= window_nxt;
      position_r     <= position_nxt;
      stream_begin_r <= stream_begin_nxt;
      begin_valid_r  <= begin_valid_nxt;
      page_start_r   <= page_start_nxt;
      phase_r        <= phase_nxt;
      countdown_r    <= countdown_nxt;
      segs_left_r    <= segs_left_nxt;
      page_len_r     <= page_len_nxt;
      finished_r     <= finished_nxt;
      set_open_r     <= set_open_nxt;
    end
  end

  a_res_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> beat_acc) else $error("result without an input beat");
  a_one_per_set: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !res.valid) else $error("second result in one data set");
  a_idle_after_find: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> phase_r == PH_SCAN) else $error("page walk after find");
  a_lacing_has_segs: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LACING |-> segs_left_r != 8'd0) else $error("lacing with no segments");

endmodule

/* design/ogg_stream_carver.sv */
// Ogg stream carver top level: stream ports, start offset register, result register.
// Takes one byte per beat and can accept a byte every cycle; the scan state is updated
// in the accepting cycle and the single result of a data set appears in the cycle after the
// byte that decides it (the byte closing the EOS page header or lacing, or the last byte).
// A held result stalls input only while out_tready is low. Each data set (ended by tlast)
// yields exactly one result; cfg_wr_data sets the position of each set's first byte.
module ogg_stream_carver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [osc_pkg::POS_W-1:0]     cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,   // last_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [osc_pkg::OUT_DATA_W-1:0] out_tdata  // [1:0] status, [33:2] begin_pos,
                                                    // [65:34] end_pos, rest zero
);
  import osc_pkg::*;

  logic [POS_W-1:0] start_offset_r;
  logic             out_valid_r;
  result_t          out_res_r;
  result_t          res;
  logic             beat_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign beat_acc  = in_tvalid && in_tready;

  osc_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_acc     (beat_acc),
    .data_byte    (in_tdata),
    .last_byte    (in_tlast),
    .start_offset (start_offset_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_offset_r <= '0;
    end else if (cfg_wr_en) begin
      start_offset_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= res.valid;
    end
  end

  // payload: load whenever the slot is free
  always_ff @(posedge clk) begin
    if (in_tready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.end_pos, out_res_r.begin_pos, out_res_r.status};

endmodule

/* dv/ogg_stream_carver_tb.sv */
// Self-checking testbench for the Ogg stream carver: directed sets, random sets and predictor.
module ogg_stream_carver_tb;
  import osc_pkg::*;

  localparam logic [31:0] OGG_MAGIC = 32'h4f676753;  // "OggS"
  localparam logic [23:0] OGG_HEAD = OGG_MAGIC[31:8];
  localparam logic [7:0] OGG_TAIL = OGG_MAGIC[7:0];
  localparam int HDR_BYTES = 27;
  localparam logic [4:0] TYPE_GAP = 5'd2;     // type byte sits two beats after the 'S'
  localparam logic [4:0] SEGCNT_GAP = 5'd21;  // segment count sits 21 beats after the type
  localparam int BOS_BIT = 1;
  localparam int EOS_BIT = 2;
  localparam int SETTLE = 3;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BYTES = 120;

  typedef struct packed {
    status_t st;
    logic [31:0] bpos;
    logic [31:0] epos;
  } carve_result_t;

  typedef struct packed {
    logic [7:0] lead;
    logic has_page;
    logic [7:0] kind;
    logic [7:0] segs;
    logic [7:0] lace;
    logic [8:0] keep;  // page bytes sent, 0 = header and lacing whole
    logic ends;
    logic known;
    carve_result_t want;
  } carve_row_t;

  localparam carve_result_t NO_RES = '0;
  localparam carve_result_t MISS = '{ST_NOT_FOUND, 32'd0, 32'd0};
  localparam carve_result_t CUT_AT0 = '{ST_TRUNCATED, 32'd0, 32'd0};

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [POS_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  ogg_stream_carver dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // predictor state
  logic [31:0] start_reg;
  logic [23:0] scan_win;
  logic [31:0] scan_pos;
  logic [31:0] bos_pos;
  logic bos_seen;
  logic [31:0] cand_pos;
  phase_t scan_phase;
  logic [4:0] wait_cnt;
  logic [7:0] lace_left;
  logic [16:0] page_len;
  logic set_done;
  logic set_active;

  carve_result_t expected_q[$];
  carve_row_t plan [17];
  bit steady = 1'b0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int bytes_live = 0;
  int found_sets = 0;
  int cut_sets = 0;
  int empty_sets = 0;
  int offsets_used = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic clear_set();
    scan_win = '0;
    scan_pos = start_reg;
    bos_pos = '0;
    bos_seen = 1'b0;
    cand_pos = '0;
    scan_phase = PH_SCAN;
    wait_cnt = '0;
    lace_left = '0;
    page_len = '0;
    set_done = 1'b0;
    set_active = 1'b0;
  endtask

  // Advance the carver state by one byte; hit marks a result.
  task automatic carve_step(input logic [7:0] b, input logic l, output bit hit,
                            output carve_result_t res);
    bit done;
    done = 1'b0;
    hit = 1'b0;
    res = NO_RES;
    if (!set_active) begin
      scan_pos = start_reg;
      set_active = 1'b1;
    end
    if (!set_done) begin
      case (scan_phase)
        PH_SCAN: begin
          if (scan_win == OGG_HEAD && b == OGG_TAIL) begin
            cand_pos = scan_pos - 32'd3;
            wait_cnt = TYPE_GAP;
            scan_phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          wait_cnt = wait_cnt - 5'd1;
          if (wait_cnt == 0) begin
            scan_phase = PH_SCAN;
            if (b[BOS_BIT]) begin
              bos_pos = cand_pos;
              bos_seen = 1'b1;
            end
            if (b[EOS_BIT] && bos_seen) begin
              scan_phase = PH_HEADER;
              wait_cnt = SEGCNT_GAP;
            end
          end
        end
        PH_HEADER: begin
          wait_cnt = wait_cnt - 5'd1;
          if (wait_cnt == 0) begin
            lace_left = b;
            page_len = 17'(HDR_BYTES) + 17'(b);
            if (b == 0) done = 1'b1;
            else scan_phase = PH_LACING;
          end
        end
        default: begin
          page_len = page_len + 17'(b);
          lace_left = lace_left - 8'd1;
          if (lace_left == 0) done = 1'b1;
        end
      endcase
      if (done) begin
        res = '{ST_FOUND, bos_pos, cand_pos + 32'(page_len)};
        hit = 1'b1;
        set_done = 1'b1;
        scan_phase = PH_SCAN;
      end
    end
    scan_win = {scan_win[15:0], b};
    scan_pos = scan_pos + 32'd1;
    if (l) begin
      if (!set_done) begin
        hit = 1'b1;
        if (scan_phase == PH_HEADER || scan_phase == PH_LACING)
          res = '{ST_TRUNCATED, bos_pos, 32'd0};
        else
          res = MISS;
      end
      clear_set();
    end
  endtask

  function automatic logic [7:0] noise_byte();
    // lean toward the capture letters so partial patterns show up often
    case ($urandom_range(9))
      0: return OGG_MAGIC[31:24];
      1: return OGG_MAGIC[23:16];
      2: return OGG_MAGIC[7:0];
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_magic(ref logic [7:0] q[$]);
    for (int k = 3; k >= 0; k--) q.push_back(OGG_MAGIC[8*k +: 8]);
  endtask

  task automatic add_noise(ref logic [7:0] q[$], input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(11) == 0) push_magic(q);
      else q.push_back(noise_byte());
    end
  endtask

  task automatic add_page(ref logic [7:0] q[$], input logic [7:0] kind, input logic [7:0] segs,
                          input bit scramble, input logic [7:0] lace);
    logic [7:0] fill [20];
    int at;
    foreach (fill[i]) fill[i] = scramble ? noise_byte() : 8'h00;
    // plant a capture pattern inside the header now and then
    if (scramble && $urandom_range(4) == 0) begin
      at = $urandom_range(16);
      for (int k = 0; k < 4; k++) fill[at+k] = OGG_MAGIC[8*(3-k) +: 8];
    end
    push_magic(q);
    q.push_back(scramble ? noise_byte() : 8'h00);
    q.push_back(kind);
    foreach (fill[i]) q.push_back(fill[i]);
    q.push_back(segs);
    for (int i = 0; i < segs; i++) q.push_back(scramble ? 8'($urandom_range(255)) : lace);
  endtask

  function automatic logic [7:0] pick_segs();
    return ($urandom_range(39) == 0) ? 8'd255 : 8'($urandom_range(4));
  endfunction

  // Build one random data set: mostly BOS ... EOS page chains, some noise, some cut short.
  task automatic make_set(ref logic [7:0] q[$]);
    logic [7:0] kind;
    int cut;
    q.delete();
    if ($urandom_range(99) < 25) begin
      add_noise(q, $urandom_range(1, 24));
    end else begin
      add_noise(q, $urandom_range(0, 5));
      if ($urandom_range(9) != 0) begin
        kind = 8'($urandom_range(255));
        kind[BOS_BIT] = 1'b1;
        kind[EOS_BIT] = 1'b0;
        add_page(q, kind, pick_segs(), 1'b1, 8'h00);
        add_noise(q, $urandom_range(0, 6));
      end
      repeat ($urandom_range(2)) begin
        kind = 8'($urandom_range(255));
        if ($urandom_range(3) != 0) kind[EOS_BIT] = 1'b0;
        add_page(q, kind, pick_segs(), 1'b1, 8'h00);
        add_noise(q, $urandom_range(0, 6));
      end
      kind = 8'($urandom_range(255));
      kind[EOS_BIT] = 1'b1;
      add_page(q, kind, pick_segs(), 1'b1, 8'h00);
      add_noise(q, $urandom_range(0, 4));
      if ($urandom_range(4) == 0) begin
        cut = $urandom_range(1, q.size());
        while (q.size() > cut) void'(q.pop_back());
      end
    end
  endtask

  task automatic tally(input status_t st);
    case (st)
      ST_FOUND: found_sets++;
      ST_TRUNCATED: cut_sets++;
      default: empty_sets++;
    endcase
  endtask

  // Drive one beat, wait for the handshake, then update the predictor.
  task automatic push_byte(input logic [7:0] b, input logic l, input bit typed,
                           input carve_result_t want);
    bit hit;
    carve_result_t res;
    while (!steady && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    if (!set_done) bytes_live++;
    carve_step(b, l, hit, res);
    if (hit) begin
      expected_q.push_back(typed ? want : res);
      tally(typed ? want.st : res.st);
    end
  endtask

  task automatic send_set(ref logic [7:0] q[$]);
    foreach (q[i]) push_byte(q[i], i == q.size() - 1, 1'b0, NO_RES);
  endtask

  // Hold off input until every pending result has come, then let the block settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_start(input logic [31:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    start_reg = v;
    offsets_used++;
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] d);
    carve_result_t w;
    if (expected_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result beat %h", d));
    end else begin
      w = expected_q.pop_front();
      if (d[1:0] != w.st)
        flag_mismatch($sformatf("status %0d, want %0d", d[1:0], w.st));
      if (d[33:2] != w.bpos)
        flag_mismatch($sformatf("begin_pos %h, want %h", d[33:2], w.bpos));
      if (d[65:34] != w.epos)
        flag_mismatch($sformatf("end_pos %h, want %h", d[65:34], w.epos));
      if (d[OUT_DATA_W-1:66] != '0)
        flag_mismatch($sformatf("pad bits %h not zero", d[OUT_DATA_W-1:66]));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
    out_tready <= steady || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending", quiet_cycles,
               expected_q.size());
      $display("ogg_stream_carver verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] row_q[$];
    logic [7:0] page_q[$];
    logic [7:0] set_q[$];
    logic [31:0] start_plan [6];
    int keep;
    int base;

    start_reg = '0;
    clear_set();
    // lead, page, kind, segs, lace, keep, ends, known, expected
    plan = '{
      '{8'd1, 1'b0, 8'h00, 8'd0,   8'h00, 9'd0,  1'b1, 1'b1, MISS},
      '{8'd0, 1'b1, 8'h06, 8'd0,   8'h00, 9'd0,  1'b1, 1'b1, '{ST_FOUND, 32'd0, 32'd27}},
      '{8'd5, 1'b1, 8'h06, 8'd255, 8'hFF, 9'd0,  1'b0, 1'b1, '{ST_FOUND, 32'd5, 32'd65312}},
      '{8'd4, 1'b0, 8'h00, 8'd0,   8'h00, 9'd0,  1'b1, 1'b0, NO_RES},
      '{8'd0, 1'b1, 8'h02, 8'd0,   8'h00, 9'd0,  1'b0, 1'b0, NO_RES},
      '{8'd2, 1'b1, 8'h04, 8'd2,   8'h10, 9'd0,  1'b1, 1'b1, '{ST_FOUND, 32'd0, 32'd90}},
      '{8'd0, 1'b1, 8'h06, 8'd3,   8'h01, 9'd28, 1'b1, 1'b1, CUT_AT0},
      '{8'd0, 1'b1, 8'h06, 8'd0,   8'h00, 9'd10, 1'b1, 1'b1, CUT_AT0},
      '{8'd0, 1'b1, 8'h06, 8'd0,   8'h00, 9'd26, 1'b1, 1'b1, CUT_AT0},
      '{8'd0, 1'b1, 8'h06, 8'd0,   8'h00, 9'd5,  1'b1, 1'b1, MISS},
      '{8'd0, 1'b1, 8'h04, 8'd0,   8'h00, 9'd0,  1'b0, 1'b0, NO_RES},
      '{8'd1, 1'b0, 8'h00, 8'd0,   8'h00, 9'd0,  1'b1, 1'b1, MISS},
      '{8'd0, 1'b1, 8'h02, 8'd0,   8'h00, 9'd0,  1'b0, 1'b0, NO_RES},
      '{8'd0, 1'b1, 8'h02, 8'd0,   8'h00, 9'd0,  1'b0, 1'b0, NO_RES},
      '{8'd0, 1'b1, 8'h04, 8'd1,   8'hFF, 9'd0,  1'b1, 1'b1, '{ST_FOUND, 32'd27, 32'd337}},
      '{8'd0, 1'b1, 8'hFF, 8'd0,   8'h00, 9'd0,  1'b1, 1'b1, '{ST_FOUND, 32'd0, 32'd27}},
      '{8'd3, 1'b1, 8'h06, 8'd1,   8'h00, 9'd0,  1'b1, 1'b0, NO_RES}
    };
    start_plan[0] = 32'hFFFF_FFFF;
    start_plan[1] = $urandom();
    start_plan[2] = 32'hFFFF_FF80;
    start_plan[3] = 32'h0000_0000;
    start_plan[4] = $urandom();
    start_plan[5] = 32'h7FFF_FFFF;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      row_q.delete();
      page_q.delete();
      repeat (plan[r].lead) row_q.push_back(8'h00);
      if (plan[r].has_page) begin
        add_page(page_q, plan[r].kind, plan[r].segs, 1'b0, plan[r].lace);
        keep = (plan[r].keep == 0) ? page_q.size() : int'(plan[r].keep);
        for (int i = 0; i < keep; i++) row_q.push_back(page_q[i]);
      end
      foreach (row_q[i])
        push_byte(row_q[i], plan[r].ends && i == row_q.size() - 1, plan[r].known, plan[r].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_start(start_plan[ph]);
      steady = (ph == 2);
      base = bytes_live;
      while (bytes_live - base < PHASE_BYTES) begin
        make_set(set_q);
        send_set(set_q);
        if ($urandom_range(9) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (expected_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    $display("summary: %0d live bytes in %0d data sets over %0d written start offsets",
             bytes_live, found_sets + cut_sets + empty_sets, offsets_used);
    $display("summary: %0d found, %0d truncated, %0d not found, %0d mismatches",
             found_sets, cut_sets, empty_sets, mismatches);
    if (mismatches == 0)
      $display("ogg_stream_carver verification clean");
    else
      $display("ogg_stream_carver verification failed");
    $finish;
  end

endmodule
